// ===== rtl/rpa_pkg.sv =====
// rpa_pkg: shared types, constants and codes of the page allocator
`timescale 1ns / 1ps

package rpa_pkg;

  localparam int MAX_PAGES  = 32768;
  localparam int PAGE_SIZE  = 4096;
  localparam int REF_WIDTH  = 16;

  localparam int PAGE_SHIFT = $clog2(PAGE_SIZE);
  localparam int IDX_W      = $clog2(MAX_PAGES);
  localparam int CNT_W      = IDX_W + 1;

  localparam int ADDR_W     = 39;
  localparam int RBASE_W    = ADDR_W + 1;
  localparam int PAGE_NUM_W = RBASE_W - PAGE_SHIFT;
  localparam int OP_W       = 3;
  localparam int PIDX_W     = 15;
  localparam int REFOUT_W   = 16;
  localparam int FREE_W     = 16;
  localparam int STATUS_W   = 2;
  localparam int PCOUNT_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 39;

  localparam logic [REF_WIDTH-1:0] REF_MAX     = '1;
  localparam logic [CNT_W-1:0]     MAX_PAGES_C = CNT_W'(MAX_PAGES);
  localparam logic [RBASE_W-1:0]   PAGE_MASK   = RBASE_W'(PAGE_SIZE - 1);

  typedef enum logic [OP_W-1:0] {
    OP_INIT      = 3'd0,
    OP_ALLOC     = 3'd1,
    OP_FREE      = 3'd2,
    OP_PIN       = 3'd3,
    OP_READ_REF  = 3'd4,
    OP_READ_FREE = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OOM       = 2'd1,
    ST_BAD_ADDR  = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_ADDRESS = 2'd0,
    CFG_PAGE_COUNT   = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INIT,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] address;
    logic [PIDX_W-1:0] page_index;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   page_address;
    logic [REFOUT_W-1:0] ref_count;
    logic [FREE_W-1:0]   free_pages;
    logic [STATUS_W-1:0] status;
  } rsp_t;

endpackage

// ===== rtl/rpa_ram.sv =====
// rpa_ram: generic single write port ram with registered read
`timescale 1ns / 1ps

module rpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/refcounted_page_allocator.sv =====
// refcounted_page_allocator: free stack page allocator with per-page reference counts
//
//   channel  direction  handshake            word
//   cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//   in       in         in_valid/in_ready    req_t
//   out      out        out_valid/out_ready  rsp_t
//
// alloc, free, pin and reads: memory read at accept, then modify and write back in S_EXEC
// init writes the clamped page count of pages in S_INIT, one page of both memories per cycle
// cfg_ready is always high; in_ready is high only while no word is being executed
// a held result stalls the write-back; the next word is not taken meanwhile
// reset clears the registers, stack depth and page count; the memories are filled by init
`timescale 1ns / 1ps

module refcounted_page_allocator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rpa_pkg::req_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rpa_pkg::rsp_t                  out_data
);

  import rpa_pkg::*;

  state_t state, state_next;

  logic [RBASE_W-1:0]   base_round;
  logic [PCOUNT_W-1:0]  page_count;
  logic [CNT_W-1:0]     stack_top, stack_top_next;
  logic [CNT_W-1:0]     init_cursor;
  logic [CNT_W-1:0]     fill;
  logic [OP_W-1:0]      op_q;
  logic [IDX_W-1:0]     idx_q;
  status_t              st_q;

  logic                 in_fire;
  logic                 exec_go;
  logic                 exec_load;
  logic [RBASE_W-1:0]   base_sum;
  logic [RBASE_W-1:0]   addr_ext;
  logic [RBASE_W-1:0]   addr_diff;
  logic [PAGE_NUM_W-1:0] page_num;
  logic [CNT_W-1:0]     clamp_n;
  logic [IDX_W-1:0]     acc_idx;
  status_t              acc_status;
  logic [REF_WIDTH-1:0] dec_cnt;
  logic [REF_WIDTH-1:0] inc_cnt;
  logic [RBASE_W-1:0]   alloc_addr;
  rsp_t                 rsp_next;

  logic                 fs_we, fs_re;
  logic [IDX_W-1:0]     fs_waddr, fs_wdata, fs_raddr, fs_rdata;
  logic                 rt_we, rt_re;
  logic [IDX_W-1:0]     rt_waddr, rt_raddr;
  logic [REF_WIDTH-1:0] rt_wdata, rt_rdata;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign exec_go   = !out_valid || out_ready;

  // config: base is rounded up to a page boundary as it is written
  assign base_sum = {1'b0, cfg_data[ADDR_W-1:0]} + PAGE_MASK;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_round <= '0;
      page_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_BASE_ADDRESS) begin
        base_round <= base_sum & ~PAGE_MASK;
      end else if (cfg_index == CFG_PAGE_COUNT) begin
        page_count <= cfg_data[PCOUNT_W-1:0];
      end
    end
  end

  // decode at accept
  assign addr_ext  = {1'b0, in_data.address};
  assign addr_diff = addr_ext - base_round;
  assign page_num  = addr_diff[RBASE_W-1:PAGE_SHIFT];
  assign clamp_n   = (32'(page_count) > 32'(MAX_PAGES)) ? MAX_PAGES_C : CNT_W'(page_count);

  always_comb begin
    acc_idx    = IDX_W'(in_data.page_index);
    acc_status = ST_OK;
    unique case (in_data.op)
      OP_ALLOC: begin
        if (stack_top == '0) begin
          acc_status = ST_OOM;
        end
      end
      OP_FREE: begin
        acc_idx = IDX_W'(page_num);
        if (in_data.address[PAGE_SHIFT-1:0] != '0 || addr_ext < base_round ||
            32'(page_num) >= 32'(init_cursor)) begin
          acc_status = ST_BAD_ADDR;
        end
      end
      OP_PIN, OP_READ_REF: begin
        if (32'(in_data.page_index) >= 32'(init_cursor)) begin
          acc_status = ST_BAD_ADDR;
        end
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = (in_data.op == OP_INIT) ? S_INIT : S_EXEC;
        end
      end
      S_INIT: begin
        if (fill >= init_cursor) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign dec_cnt    = rt_rdata - REF_WIDTH'(1);
  assign inc_cnt    = (rt_rdata == REF_MAX) ? rt_rdata : rt_rdata + REF_WIDTH'(1);
  assign alloc_addr = base_round + (RBASE_W'(fs_rdata) << PAGE_SHIFT);

  // memory control and result
  always_comb begin
    fs_we          = 1'b0;
    fs_waddr       = fill[IDX_W-1:0];
    fs_wdata       = fill[IDX_W-1:0];
    fs_re          = 1'b0;
    fs_raddr       = IDX_W'(stack_top - CNT_W'(1));
    rt_we          = 1'b0;
    rt_waddr       = fill[IDX_W-1:0];
    rt_wdata       = '0;
    rt_re          = 1'b0;
    rt_raddr       = acc_idx;
    stack_top_next = stack_top;
    exec_load      = 1'b0;
    rsp_next       = '0;
    rsp_next.status = ST_OK;
    unique case (state)
      S_IDLE: begin
        fs_re = in_fire && (in_data.op == OP_ALLOC) && (stack_top != '0);
        rt_re = in_fire && acc_status == ST_OK &&
                (in_data.op == OP_FREE || in_data.op == OP_PIN || in_data.op == OP_READ_REF);
      end
      S_INIT: begin
        if (fill < init_cursor) begin
          fs_we = 1'b1;
          rt_we = 1'b1;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          exec_load = 1'b1;
          unique case (op_q)
            OP_INIT: begin
              stack_top_next = init_cursor;
            end
            OP_ALLOC: begin
              if (st_q != ST_OK) begin
                rsp_next.status = st_q;
              end else begin
                rt_we                 = 1'b1;
                rt_waddr              = fs_rdata;
                rt_wdata              = REF_WIDTH'(1);
                stack_top_next        = stack_top - CNT_W'(1);
                rsp_next.ref_count    = REFOUT_W'(1);
                rsp_next.page_address = alloc_addr[ADDR_W-1:0];
              end
            end
            OP_FREE: begin
              if (st_q != ST_OK) begin
                rsp_next.status = st_q;
              end else if (rt_rdata == '0) begin
                rsp_next.status = ST_UNDERFLOW;
              end else begin
                rt_we              = 1'b1;
                rt_waddr           = idx_q;
                rt_wdata           = dec_cnt;
                rsp_next.ref_count = REFOUT_W'(dec_cnt);
                if (dec_cnt == '0 && stack_top < init_cursor) begin
                  fs_we          = 1'b1;
                  fs_waddr       = stack_top[IDX_W-1:0];
                  fs_wdata       = idx_q;
                  stack_top_next = stack_top + CNT_W'(1);
                end
              end
            end
            OP_PIN: begin
              if (st_q != ST_OK) begin
                rsp_next.status = st_q;
              end else begin
                rt_we              = 1'b1;
                rt_waddr           = idx_q;
                rt_wdata           = inc_cnt;
                rsp_next.ref_count = REFOUT_W'(inc_cnt);
              end
            end
            OP_READ_REF: begin
              if (st_q != ST_OK) begin
                rsp_next.status = st_q;
              end else begin
                rsp_next.ref_count = REFOUT_W'(rt_rdata);
              end
            end
            default: begin
            end
          endcase
          rsp_next.free_pages = FREE_W'(stack_top_next);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      stack_top   <= '0;
      init_cursor <= '0;
      fill        <= '0;
    end else begin
      state <= state_next;
      if (in_fire && in_data.op == OP_INIT) begin
        init_cursor <= clamp_n;
        stack_top   <= '0;
        fill        <= '0;
      end else begin
        stack_top <= stack_top_next;
        if (state == S_INIT && fill < init_cursor) begin
          fill <= fill + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q  <= in_data.op;
      idx_q <= acc_idx;
      st_q  <= acc_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_load) begin
      out_data <= rsp_next;
    end
  end

  rpa_ram #(
    .WIDTH(IDX_W),
    .DEPTH(MAX_PAGES)
  ) u_free_stack (
    .clk  (clk),
    .we   (fs_we),
    .waddr(fs_waddr),
    .wdata(fs_wdata),
    .re   (fs_re),
    .raddr(fs_raddr),
    .rdata(fs_rdata)
  );

  rpa_ram #(
    .WIDTH(REF_WIDTH),
    .DEPTH(MAX_PAGES)
  ) u_ref_table (
    .clk  (clk),
    .we   (rt_we),
    .waddr(rt_waddr),
    .wdata(rt_wdata),
    .re   (rt_re),
    .raddr(rt_raddr),
    .rdata(rt_rdata)
  );

  a_top_in_range: assert property (@(posedge clk) disable iff (rst)
    stack_top <= init_cursor)
    else $error("free stack deeper than managed pages");

  a_cursor_max: assert property (@(posedge clk) disable iff (rst)
    init_cursor <= MAX_PAGES_C)
    else $error("page count above capacity");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !fs_we && !rt_we)
    else $error("memory write while idle");

  a_read_at_accept: assert property (@(posedge clk) disable iff (rst)
    (fs_re || rt_re) |-> in_fire)
    else $error("memory read outside accept");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_INIT |-> fill <= init_cursor)
    else $error("init fill ran past page count");

endmodule

// ===== tb/refcounted_page_allocator_tb.sv =====
// refcounted_page_allocator_tb: self-checking bench for the reference-counted page allocator
`timescale 1ns / 1ps

module refcounted_page_allocator_tb;
  import rpa_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int IDLE_PCT    = 28;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_BASE_ADDRESS;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  req_t                  in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  rsp_t                  out_data;

  // allocator state as the bench sees it
  logic [IDX_W-1:0] free_idx [MAX_PAGES];
  int unsigned      depth;
  int unsigned      refs [MAX_PAGES];
  int unsigned      live_pages;
  longint unsigned  base_reg;
  int unsigned      count_reg;

  rsp_t pending_replies [$];
  int   failures = 0;
  int   cycles   = 0;
  bit   steady   = 1'b0;

  refcounted_page_allocator DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic longint unsigned rounded_base();
    return ((base_reg + PAGE_SIZE - 1) / PAGE_SIZE) * PAGE_SIZE;
  endfunction

  function automatic logic [ADDR_W-1:0] page_addr(input int unsigned idx);
    return ADDR_W'(rounded_base() + 64'(idx) * PAGE_SIZE);
  endfunction

  function automatic void push_free(input int unsigned idx);
    if (depth < live_pages && depth < MAX_PAGES) begin
      free_idx[depth] = IDX_W'(idx);
      depth++;
    end
  endfunction

  function automatic rsp_t allocator_reply(input req_t w);
    rsp_t            r;
    longint unsigned rbase;
    longint unsigned off;
    int unsigned     idx;
    int unsigned     n;
    r      = '0;
    rbase  = rounded_base();
    r.status = ST_OK;
    case (w.op)
      OP_INIT: begin
        n = (count_reg > MAX_PAGES) ? MAX_PAGES : count_reg;
        live_pages = n;
        depth = 0;
        for (int i = 0; i < n; i++) begin
          refs[i] = 0;
          push_free(i);
        end
      end
      OP_ALLOC: begin
        if (depth == 0) begin
          r.status = ST_OOM;
        end else begin
          depth--;
          idx = 32'(free_idx[depth]);
          refs[idx] = 1;
          r.ref_count = REFOUT_W'(1);
          r.page_address = ADDR_W'(rbase + 64'(idx) * PAGE_SIZE);
        end
      end
      OP_FREE: begin
        if (w.address[PAGE_SHIFT-1:0] != 0 || 64'(w.address) < rbase) begin
          r.status = ST_BAD_ADDR;
        end else begin
          off = (64'(w.address) - rbase) / PAGE_SIZE;
          if (off >= live_pages) begin
            r.status = ST_BAD_ADDR;
          end else begin
            idx = 32'(off);
            if (refs[idx] == 0) begin
              r.status = ST_UNDERFLOW;
            end else begin
              refs[idx]--;
              r.ref_count = REFOUT_W'(refs[idx]);
              if (refs[idx] == 0) push_free(idx);
            end
          end
        end
      end
      OP_PIN: begin
        if (w.page_index >= live_pages) begin
          r.status = ST_BAD_ADDR;
        end else begin
          if (refs[w.page_index] < REF_MAX) refs[w.page_index]++;
          r.ref_count = REFOUT_W'(refs[w.page_index]);
        end
      end
      OP_READ_REF: begin
        if (w.page_index >= live_pages) r.status = ST_BAD_ADDR;
        else r.ref_count = REFOUT_W'(refs[w.page_index]);
      end
      default: begin
      end
    endcase
    r.free_pages = FREE_W'(depth);
    return r;
  endfunction

  always @(posedge clk) out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

  always @(posedge clk) begin : check_replies
    rsp_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected result word %h", out_data);
        failures++;
      end else begin
        want = pending_replies.pop_front();
        if (out_data.page_address !== want.page_address) begin
          $error("page_address: expected %h, got %h", want.page_address, out_data.page_address);
          failures++;
        end
        if (out_data.ref_count !== want.ref_count) begin
          $error("ref_count: expected %0d, got %0d", want.ref_count, out_data.ref_count);
          failures++;
        end
        if (out_data.free_pages !== want.free_pages) begin
          $error("free_pages: expected %0d, got %0d", want.free_pages, out_data.free_pages);
          failures++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic req_t make_word(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                                     input logic [PIDX_W-1:0] pidx);
    req_t w;
    w.op         = op;
    w.address    = addr;
    w.page_index = pidx;
    return w;
  endfunction

  function automatic int unsigned pick_index();
    return (live_pages == 0) ? 0 : $urandom_range(0, live_pages - 1);
  endfunction

  // prefer a page that is currently held so frees mostly succeed
  function automatic int unsigned held_page();
    int unsigned idx;
    idx = pick_index();
    for (int t = 0; t < 8 && refs[idx] == 0 && live_pages != 0; t++) idx = pick_index();
    return idx;
  endfunction

  function automatic req_t random_word();
    req_t        w;
    int unsigned pick;
    w.op         = OP_READ_FREE;
    w.address    = ADDR_W'({$urandom, $urandom});
    w.page_index = PIDX_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 26) begin
      w.op = OP_ALLOC;
    end else if (pick < 52) begin
      w.op = OP_FREE;
      w.address = page_addr(held_page());
    end else if (pick < 60) begin
      w.op = OP_FREE;
      if ($urandom_range(0, 1))
        w.address = page_addr(pick_index() + $urandom_range(0, 2)) |
                    ADDR_W'($urandom_range(0, PAGE_SIZE - 1));
    end else if (pick < 72) begin
      w.op = OP_PIN;
      w.page_index = PIDX_W'(pick_index());
    end else if (pick < 82) begin
      w.op = OP_READ_REF;
      w.page_index = PIDX_W'(pick_index());
    end else if (pick < 88) begin
      w.op = $urandom_range(0, 1) ? OP_PIN : OP_READ_REF;
    end else if (pick < 94) begin
      w.op = OP_READ_FREE;
    end else if (pick < 97) begin
      w.op = OP_INIT;
    end else begin
      w.op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
    end
    return w;
  endfunction

  task automatic send_word(input req_t w);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_replies.push_back(allocator_reply(w));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(input logic [ADDR_W-1:0] base, input logic [PCOUNT_W-1:0] pages);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_BASE_ADDRESS;
    cfg_data  <= CFG_DATA_W'(base);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    base_reg = 64'(base);
    cfg_index <= CFG_PAGE_COUNT;
    cfg_data  <= CFG_DATA_W'(pages);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    count_reg = 32'(pages);
    cfg_valid <= 1'b0;
  endtask

  // registers still at their reset values
  task automatic test_before_init();
    send_word(make_word(OP_ALLOC, '0, '0));
    send_word(make_word(OP_FREE, '0, '0));
    send_word(make_word(OP_PIN, '0, '0));
    send_word(make_word(OP_READ_REF, '0, '0));
    send_word(make_word(OP_READ_FREE, '1, '1));
    send_word(make_word(OP_SPARE_6, '0, '0));
    send_word(make_word(OP_SPARE_7, '1, '1));
    send_word(make_word(OP_INIT, '0, '0));
    send_word(make_word(OP_ALLOC, '0, '0));
  endtask

  task automatic test_basic_ops();
    wait_idle();
    set_regs(39'h10_0000_0801, 16'd4);
    send_word(make_word(OP_INIT, '0, '0));
    send_word(make_word(OP_ALLOC, '1, '1));
    send_word(make_word(OP_ALLOC, '0, '0));
    send_word(make_word(OP_PIN, '0, 15'd3));
    send_word(make_word(OP_READ_REF, '0, 15'd3));
    send_word(make_word(OP_READ_FREE, '0, '0));
    send_word(make_word(OP_FREE, page_addr(3) + 1, '0));
    send_word(make_word(OP_FREE, '0, '0));
    send_word(make_word(OP_FREE, '1, '0));
    send_word(make_word(OP_FREE, page_addr(4), '0));
    repeat (3) send_word(make_word(OP_FREE, page_addr(3), '0));
    send_word(make_word(OP_PIN, '0, '1));
    send_word(make_word(OP_READ_REF, '0, '1));
    repeat (4) send_word(make_word(OP_ALLOC, '0, '0));
    send_word(make_word(OP_INIT, '0, '0));
    send_word(make_word(OP_READ_REF, '0, 15'd2));
  endtask

  // a page that is already free gets pinned and freed with the stack full
  task automatic test_stack_full();
    send_word(make_word(OP_PIN, '0, 15'd0));
    send_word(make_word(OP_FREE, page_addr(0), '0));
    send_word(make_word(OP_READ_FREE, '0, '0));
    send_word(make_word(OP_ALLOC, '0, '0));
  endtask

  task automatic test_extreme_config();
    wait_idle();
    set_regs('1, 16'd3);
    send_word(make_word(OP_INIT, '0, '0));
    send_word(make_word(OP_ALLOC, '0, '0));
    send_word(make_word(OP_FREE, 39'h2000, '0));
    wait_idle();
    set_regs(39'h7F_FFFF_E000, 16'd3);
    send_word(make_word(OP_INIT, '0, '0));
    repeat (2) send_word(make_word(OP_ALLOC, '0, '0));
    send_word(make_word(OP_FREE, 39'h7F_FFFF_F000, '0));
    send_word(make_word(OP_FREE, '0, '0));
    wait_idle();
    set_regs('0, 16'hFFFF);
    send_word(make_word(OP_INIT, '0, '0));
    send_word(make_word(OP_ALLOC, '0, '0));
    send_word(make_word(OP_READ_FREE, '0, '0));
    send_word(make_word(OP_PIN, '0, '1));
    wait_idle();
    set_regs(39'h12_3456_7000, 16'd32768);
    send_word(make_word(OP_INIT, '0, '0));
    send_word(make_word(OP_ALLOC, '0, '0));
    send_word(make_word(OP_READ_REF, '0, '1));
  endtask

  task automatic test_pin_counts();
    wait_idle();
    steady = 1'b1;
    set_regs(39'h4000, 16'd1);
    send_word(make_word(OP_INIT, '0, '0));
    repeat (10) send_word(make_word(OP_PIN, '0, '0));
    send_word(make_word(OP_READ_REF, '0, '0));
    send_word(make_word(OP_FREE, page_addr(0), '0));
    wait_idle();
    steady = 1'b0;
  endtask

  task automatic test_random_mix();
    logic [ADDR_W-1:0]   base;
    logic [PCOUNT_W-1:0] pages;
    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(0, 3))
        0: base = '0;
        1: base = ADDR_W'({$urandom, $urandom}) & ~ADDR_W'(PAGE_SIZE - 1);
        2: base = ADDR_W'({$urandom, $urandom});
        default: base = '1 - ADDR_W'($urandom_range(0, 64) * PAGE_SIZE);
      endcase
      pages = (phase == 4) ? PCOUNT_W'($urandom_range(200, 400))
                           : PCOUNT_W'($urandom_range(1, 40));
      wait_idle();
      steady = (phase == 2);
      set_regs(base, pages);
      send_word(make_word(OP_INIT, '0, '0));
      repeat (65) send_word(random_word());
    end
    wait_idle();
    steady = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_before_init();
    test_basic_ops();
    test_stack_full();
    test_extreme_config();
    test_pin_counts();
    test_random_mix();
    wait_idle();
    repeat (12) @(posedge clk);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rpa_pkg.sv
rtl/rpa_ram.sv
rtl/refcounted_page_allocator.sv
tb/refcounted_page_allocator_tb.sv
